FILE: rtl/deq_pkg.sv
// Package for the double-ended queue: opcodes, status codes, field widths and shared types.
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int OPCODE_W      = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    typedef struct packed {
        logic load;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
    parameter int WIDTH = deq_pkg::WORD_W,
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/deq_ctrl.sv
// Controller state machine: takes a request, then presents its result until taken.
`default_nettype none

module deq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output deq_pkg::cmd_t      cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = deq_pkg::S_RESP;
                end
            end
            deq_pkg::S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == deq_pkg::S_IDLE);
    assign m_tvalid = (state_reg == deq_pkg::S_RESP);
    assign cmd.load = s_tvalid && s_tready;

endmodule

`default_nettype wire

FILE: rtl/deq_dpath.sv
// Datapath: front pointer, count, status decode and ring store addressing.
`default_nettype none

module deq_dpath #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire deq_pkg::cmd_t               cmd,
    input  wire logic [deq_pkg::OPCODE_W-1:0] opcode,
    input  wire logic [deq_pkg::WORD_W-1:0]   value,
    input  wire logic [PW-1:0]               position,
    output logic      [deq_pkg::WORD_W-1:0]   data,
    output logic      [deq_pkg::STATUS_W-1:0] status,
    output logic      [CW-1:0]               occupancy
);

    localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST    = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

    logic [PW-1:0]           front_reg, front_next;
    logic [CW-1:0]           count_reg, count_next;
    deq_pkg::status_t        status_reg, status_next;
    logic                    rd_sel_reg, rd_sel_next;

    logic                    wr_en;
    logic [PW-1:0]           wr_addr;
    logic                    rd_en;
    logic [PW-1:0]           rd_addr;
    logic [deq_pkg::WORD_W-1:0] rd_data;

    logic                    full;
    logic                    empty;
    logic [PW-1:0]           front_dec;
    logic [PW-1:0]           front_inc;
    logic [PW-1:0]           count_lo;
    logic [PW-1:0]           count_m1;

    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                              input logic [PW-1:0] k);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, k};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[PW-1:0];
    endfunction

    assign full      = (count_reg == FULL_C);
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST) ? '0 : front_reg + 1'b1;
    assign count_lo  = count_reg[PW-1:0];
    assign count_m1  = PW'(count_reg - 1'b1);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = deq_pkg::ST_OK;
        rd_sel_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = slot_of(front_reg, count_lo);
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        unique case (opcode)
            deq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = cmd.load;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                wr_addr = front_dec;
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = cmd.load;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                rd_addr = slot_of(front_reg, count_m1);
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en       = cmd.load;
                    rd_sel_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en       = cmd.load;
                    rd_sel_next = 1'b1;
                    front_next  = front_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_READ:
            begin
                rd_addr = slot_of(front_reg, position);
                if (CW'(position) >= count_reg)
                begin
                    status_next = deq_pkg::ST_INDEX;
                end
                else
                begin
                    rd_en       = cmd.load;
                    rd_sel_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            status_reg <= deq_pkg::ST_OK;
            rd_sel_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            rd_sel_reg <= rd_sel_next;
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign data      = rd_sel_reg ? rd_data : '0;
    assign status    = status_reg;
    assign occupancy = count_reg;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a ring store.
//
// Requests enter on the slave stream: s_tuser carries the opcode (push back,
// push front, pop back, pop front, read at index), s_tdata the value and the
// position. Each request yields one result on the master stream: m_tdata
// carries the popped or read word and the occupancy after the request,
// m_tuser the status (ok, empty, full, bad index).
// The result is valid in the cycle after the request is taken, since the
// ring store read is registered. One request is in flight at a time: the
// controller accepts it and accesses the store port, then presents the
// result. While the result waits for m_tready, s_tready stays low and the
// queue holds; a stalled receiver simply stretches the item time.
// Reset empties the queue (front pointer and count cleared) and drops any
// pending result; the store contents are not cleared.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH   = deq_pkg::DEPTH_DEFAULT,
    localparam int PW     = $clog2(DEPTH),
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int IN_W   = ((deq_pkg::WORD_W + PW + 7) / 8) * 8,
    localparam int OUT_W  = ((deq_pkg::WORD_W + CW + 7) / 8) * 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [IN_W-1:0]              s_tdata,   // value, position
    input  wire logic [deq_pkg::OPCODE_W-1:0] s_tuser,   // opcode
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [OUT_W-1:0]             m_tdata,   // data, occupancy
    output logic      [deq_pkg::STATUS_W-1:0] m_tuser    // status
);

    deq_pkg::cmd_t              cmd;
    logic [deq_pkg::WORD_W-1:0] data;
    logic [CW-1:0]              occupancy;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .opcode    (s_tuser),
        .value     (s_tdata[deq_pkg::WORD_W-1:0]),
        .position  (s_tdata[deq_pkg::WORD_W +: PW]),
        .data      (data),
        .status    (m_tuser),
        .occupancy (occupancy)
    );

    assign m_tdata = OUT_W'({occupancy, data});

endmodule

`default_nettype wire

FILE: tb/double_ended_queue_test.sv
// Self-checking testbench for the ring-buffer double-ended queue with random stream stalls.
`timescale 1ns / 1ps

module double_ended_queue_test;

    localparam int DEPTH    = deq_pkg::DEPTH_DEFAULT;
    localparam int WORD_W   = deq_pkg::WORD_W;
    localparam int OPCODE_W = deq_pkg::OPCODE_W;
    localparam int STATUS_W = deq_pkg::STATUS_W;
    localparam int PW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int IN_W     = ((WORD_W + PW + 7) / 8) * 8;
    localparam int OUT_W    = ((WORD_W + CW + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;
    localparam logic [WORD_W-1:0]   WORD_MIN     = 32'h8000_0000;
    localparam logic [WORD_W-1:0]   WORD_MAX     = 32'h7fff_ffff;

    typedef struct {
        logic [WORD_W-1:0] data;
        deq_pkg::status_t  status;
        logic [CW-1:0]     occupancy;
    } deq_result_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;   // value, position
    logic [OPCODE_W-1:0] s_tuser  = '0;   // opcode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;         // data, occupancy
    logic [STATUS_W-1:0] m_tuser;         // status

    deq_result_t       pending_results[$];
    deq_result_t       arrived_expect;
    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [PW-1:0]     front_idx  = '0;
    logic [CW-1:0]     word_count = '0;
    int                idle_pct   = 22;
    int                stall_pct  = 22;
    int                mismatch_count = 0;

    double_ended_queue #(.DEPTH(DEPTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
    begin
        if (mismatch_count < 200)
            $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        mismatch_count++;
    end
    endtask

    function automatic void predict_deque_result(input logic [OPCODE_W-1:0] op,
                                                 input logic [WORD_W-1:0] value,
                                                 input logic [PW-1:0] position);
        deq_result_t r;
        r.data   = '0;
        r.status = deq_pkg::ST_OK;
        case (op)
            deq_pkg::OP_PUSH_BACK:
            begin
                if (word_count >= DEPTH)
                    r.status = deq_pkg::ST_FULL;
                else
                begin
                    ring_words[(int'(front_idx) + int'(word_count)) % DEPTH] = value;
                    word_count++;
                end
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (word_count >= DEPTH)
                    r.status = deq_pkg::ST_FULL;
                else
                begin
                    front_idx = PW'((int'(front_idx) + DEPTH - 1) % DEPTH);
                    ring_words[front_idx] = value;
                    word_count++;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (word_count == 0)
                    r.status = deq_pkg::ST_EMPTY;
                else
                begin
                    word_count--;
                    r.data = ring_words[(int'(front_idx) + int'(word_count)) % DEPTH];
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (word_count == 0)
                    r.status = deq_pkg::ST_EMPTY;
                else
                begin
                    r.data = ring_words[front_idx];
                    front_idx = PW'((int'(front_idx) + 1) % DEPTH);
                    word_count--;
                end
            end
            deq_pkg::OP_READ:
            begin
                if (position >= word_count)
                    r.status = deq_pkg::ST_INDEX;
                else
                    r.data = ring_words[(int'(front_idx) + int'(position)) % DEPTH];
            end
            default:
            begin
            end
        endcase
        r.occupancy = word_count;
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] value,
                                input logic [PW-1:0] position);
    begin
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W - WORD_W - PW){1'b0}}, position, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_deque_result(op, value, position);
    end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata[WORD_W-1:0], '0);
            else
            begin
                arrived_expect = pending_results[0];
                pending_results.delete(0);
                if (m_tdata[WORD_W-1:0] !== arrived_expect.data)
                    report_mismatch("data", m_tdata[WORD_W-1:0], arrived_expect.data);
                if (m_tuser !== arrived_expect.status)
                    report_mismatch("status", WORD_W'(m_tuser), WORD_W'(arrived_expect.status));
                if (m_tdata[WORD_W +: CW] !== arrived_expect.occupancy)
                    report_mismatch("occupancy", WORD_W'(m_tdata[WORD_W +: CW]),
                                    WORD_W'(arrived_expect.occupancy));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic test_empty_queue;
    begin
        send_request(deq_pkg::OP_POP_BACK, $urandom, PW'($urandom));
        send_request(deq_pkg::OP_POP_FRONT, $urandom, PW'($urandom));
        send_request(deq_pkg::OP_READ, $urandom, '0);
        send_request(deq_pkg::OP_READ, $urandom, PW'(DEPTH - 1));
        send_request(OP_UNUSED_LO, $urandom, PW'($urandom));
        send_request(OP_UNUSED_HI, $urandom, PW'($urandom));
    end
    endtask

    task automatic test_fill_to_full;
    begin
        send_request(deq_pkg::OP_PUSH_FRONT, WORD_MIN, PW'($urandom));
        send_request(deq_pkg::OP_PUSH_BACK, WORD_MAX, PW'($urandom));
        send_request(deq_pkg::OP_PUSH_FRONT, '1, PW'($urandom));
        send_request(deq_pkg::OP_PUSH_BACK, '0, PW'($urandom));
        while (word_count < DEPTH)
            send_request($urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                         $urandom, PW'($urandom));
        send_request(deq_pkg::OP_PUSH_BACK, $urandom, PW'($urandom));
        send_request(deq_pkg::OP_PUSH_FRONT, $urandom, PW'($urandom));
        send_request(deq_pkg::OP_READ, $urandom, PW'(DEPTH - 1));
        send_request(deq_pkg::OP_READ, $urandom, '0);
    end
    endtask

    task automatic test_random_traffic(input int count);
        int                  fill_bias;
        int                  run_left;
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [WORD_W-1:0]   value;
        logic [PW-1:0]       position;
    begin
        run_left = 0;
        fill_bias = 50;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                fill_bias = $urandom_range(0, 1) ? 75 : 25;
                run_left  = $urandom_range(8, 40);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else if (pick < 23)
                op = deq_pkg::OP_READ;
            else if ($urandom_range(0, 99) < fill_bias)
                op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
            if ($urandom_range(0, 15) == 0)
                value = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
            else
                value = $urandom;
            if (op == deq_pkg::OP_READ && word_count > 0 && $urandom_range(0, 3) != 0)
                position = PW'($urandom_range(0, int'(word_count) - 1));
            else
                position = PW'($urandom);
            send_request(op, value, position);
        end
    end
    endtask

    task automatic test_back_to_back(input int count);
        int saved_idle;
        int saved_stall;
    begin
        saved_idle  = idle_pct;
        saved_stall = stall_pct;
        idle_pct    = 0;
        stall_pct   = 0;
        test_random_traffic(count);
        idle_pct    = saved_idle;
        stall_pct   = saved_stall;
    end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue;
        test_fill_to_full;
        test_random_traffic(600);
        test_back_to_back(450);
        test_random_traffic(600);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dpath.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_test.sv
